### rtl/mdns_rrp_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and field codes for the mDNS response record parser.
// No dependencies; every other file imports this package.
package mdns_rrp_pkg;

	localparam int PACKET_BYTES = 1024;
	localparam int NAME_BYTES   = 256;
	localparam int TEXT_BYTES   = 512;

	localparam int PAW   = $clog2(PACKET_BYTES);
	localparam int PCW   = $clog2(PACKET_BYTES + 1);
	localparam int NAW   = $clog2(NAME_BYTES);
	localparam int NCW   = $clog2(NAME_BYTES + 1);
	localparam int TAW   = $clog2(TEXT_BYTES);
	localparam int TCW   = $clog2(TEXT_BYTES + 1);
	// walk positions can run past the packet by a record data length
	localparam int POS_W = $clog2(PACKET_BYTES + 65536 + 512);

	localparam int CQ_DEPTH = 4;
	localparam int CQ_PW    = $clog2(CQ_DEPTH);
	localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

	localparam logic [1:0] OP_PACKET    = 2'd0;
	localparam logic [1:0] OP_READ_NAME = 2'd1;
	localparam logic [1:0] OP_READ_TEXT = 2'd2;

	localparam int          HDR_LEN  = 12;
	localparam logic [7:0]  PTR_MARK = 8'hC0;
	localparam logic [7:0]  DOT_CHAR = 8'h2E;
	localparam logic [15:0] TYPE_A   = 16'd1;
	localparam logic [15:0] TYPE_PTR = 16'd12;
	localparam logic [15:0] TYPE_TXT = 16'd16;
	localparam logic [15:0] TYPE_SRV = 16'd33;

	typedef enum logic [1:0] {
		CMD_BYTE,
		CMD_LAST,
		CMD_RD_NAME,
		CMD_RD_TEXT
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  data;
		logic [8:0]  idx;
	} cmd_t;

	typedef enum logic [1:0] {
		RK_SUMMARY = 2'd0,
		RK_NAME    = 2'd1,
		RK_TEXT    = 2'd2
	} res_kind_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_SHORT    = 3'd1,
		ST_NOT_RESP = 3'd2,
		ST_HAS_Q    = 3'd3,
		ST_NO_REC   = 3'd4,
		ST_OVERRUN  = 3'd5
	} status_t;

	typedef struct packed {
		res_kind_t   kind;
		status_t     status;
		logic [31:0] addr;
		logic [15:0] port;
		logic [8:0]  nlen;
		logic [9:0]  tlen;
		logic        terr;
		logic [7:0]  data;
	} res_t;

endpackage

### rtl/mdns_rrp_front.sv
`timescale 1ns / 1ps
// Front end: takes input transfers, classifies them into commands and queues them.
// Depends on mdns_rrp_pkg.
module mdns_rrp_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         operation,
	input  logic [7:0]         packet_byte,
	input  logic               last_byte,
	input  logic [8:0]         read_index,
	output logic               cq_vld,
	output mdns_rrp_pkg::cmd_t cq_head,
	input  logic               cq_pop
);
	import mdns_rrp_pkg::*;

	cmd_t              q_q [CQ_DEPTH];
	logic [CQ_PW-1:0]  wp_q;
	logic [CQ_PW-1:0]  rp_q;
	logic [CQ_CW-1:0]  cnt_q;
	logic              accept;
	logic              enq;
	cmd_t              cmd;

	assign full    = cnt_q == CQ_CW'(CQ_DEPTH);
	assign accept  = push && !full;
	assign cq_vld  = cnt_q != '0;
	assign cq_head = q_q[rp_q];

	always_comb begin
		cmd.data = packet_byte;
		cmd.idx  = read_index;
		enq      = accept;
		unique case (operation)
			OP_PACKET:    cmd.kind = last_byte ? CMD_LAST : CMD_BYTE;
			OP_READ_NAME: cmd.kind = CMD_RD_NAME;
			OP_READ_TEXT: cmd.kind = CMD_RD_TEXT;
			default: begin
				// undefined operation: taken and dropped
				cmd.kind = CMD_BYTE;
				enq      = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (enq) begin
			q_q[wp_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (enq) begin
				wp_q <= wp_q + 1'b1;
			end
			if (cq_pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (enq && !cq_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!enq && cq_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CQ_CW'(CQ_DEPTH))
		else $error("command queue count above depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cq_pop |-> cnt_q != '0)
		else $error("command popped from empty queue");

endmodule

### rtl/mdns_rrp_engine.sv
`timescale 1ns / 1ps
// Back end: packet buffer, header check, record walk, name and text stores, reads.
// Depends on mdns_rrp_pkg.
module mdns_rrp_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cq_vld,
	input  mdns_rrp_pkg::cmd_t cq_head,
	output logic               cq_pop,
	output logic               res_vld,
	output mdns_rrp_pkg::res_t res,
	input  logic               res_rdy
);
	import mdns_rrp_pkg::*;

	localparam int NXW = (NCW > 9) ? NCW : 9;
	localparam int TXW = (TCW > 9) ? TCW : 9;

	typedef enum logic [4:0] {
		S_IDLE, S_RD1, S_RD2, S_START, S_WAIT, S_HDR, S_REC, S_SKIP, S_RRH,
		S_GF, S_GD, S_GEND, S_NEXT, S_NW, S_NWF, S_BRA, S_BRF, S_BRC, S_BRL,
		S_BRE, S_BRA2, S_CP, S_CPD, S_TX, S_TXL, S_TEND, S_FIN, S_OUT
	} state_t;

	typedef enum logic [1:0] {G_RR, G_A, G_SRV} gmode_t;

	logic [7:0] pkt_mem  [PACKET_BYTES];
	logic [7:0] name_mem [NAME_BYTES];
	logic [7:0] text_mem [TEXT_BYTES];

	state_t            state_q, ret_q, cret_q;
	gmode_t            gmode_q;
	logic [PCW-1:0]    pcnt_q;
	logic [POS_W-1:0]  pa_q, pos_q, wp_q, nstart_q;
	logic [7:0]        pkt_s1;
	logic              hit_s1;
	logic [15:0]       rec_q, total_q, rdlen_q;
	logic [7:0]        hi_q, cp_n_q;
	logic [31:0]       sh_q;
	logic [1:0]        f_q;
	logic [16:0]       used_q;
	logic              first_q, cp_txt_q, rd_txt_q, rd_ok_q;
	logic [NCW-1:0]    ncnt_q, nhw_q;
	logic [TCW-1:0]    tcnt_q, thw_q;
	logic [31:0]       addr_q;
	logic [15:0]       port_q;
	logic              terr_q;
	status_t           status_q;
	res_t              res_q;
	logic              nwe_q, twe_q;
	logic [NAW-1:0]    nwa_q, nra_q;
	logic [TAW-1:0]    twa_q, tra_q;
	logic [7:0]        nwd_q, twd_q, nrd_s1, trd_s1;

	logic [7:0]        pb;
	logic [POS_W-1:0]  rxl;
	logic [3:0]        goff;
	logic              glast;
	logic              n_put, t_put, t_term, pwe;
	logic [7:0]        n_byte;
	logic [NXW-1:0]    nidx;
	logic [TXW-1:0]    tidx;
	logic [15:0]       hsum;

	// a byte at or past the packet end reads as zero
	assign pb      = hit_s1 ? pkt_s1 : 8'd0;
	assign rxl     = POS_W'(pcnt_q);
	assign nidx    = NXW'(cq_head.idx);
	assign tidx    = TXW'(cq_head.idx);
	assign hsum    = total_q + {hi_q, pb};
	assign cq_pop  = (state_q == S_IDLE) && cq_vld;
	assign pwe     = cq_pop && (cq_head.kind == CMD_BYTE || cq_head.kind == CMD_LAST)
		&& (pcnt_q < PCW'(PACKET_BYTES));
	assign res_vld = state_q == S_OUT;
	assign res     = res_q;

	always_ff @(posedge clk) begin
		if (pwe) begin
			pkt_mem[pcnt_q[PAW-1:0]] <= cq_head.data;
		end
		pkt_s1 <= pkt_mem[pa_q[PAW-1:0]];
		hit_s1 <= pa_q < rxl;
	end

	always_ff @(posedge clk) begin
		if (nwe_q) begin
			name_mem[nwa_q] <= nwd_q;
		end
		nrd_s1 <= name_mem[nra_q];
	end

	always_ff @(posedge clk) begin
		if (twe_q) begin
			text_mem[twa_q] <= twd_q;
		end
		trd_s1 <= text_mem[tra_q];
	end

	// record header: type at 0..1, data length at 8..9; A data at 10..13; SRV port at 14..15
	always_comb begin
		unique case (gmode_q)
			G_RR:    goff = f_q[1] ? {3'b100, f_q[0]} : {3'b000, f_q[0]};
			G_A:     goff = 4'd10 + {2'b00, f_q};
			G_SRV:   goff = 4'd14 + {2'b00, f_q};
			default: goff = 4'd0;
		endcase
		glast = (gmode_q == G_SRV) ? (f_q == 2'd1) : (f_q == 2'd3);
	end

	always_comb begin
		n_put  = 1'b0;
		n_byte = DOT_CHAR;
		t_put  = 1'b0;
		t_term = 1'b0;
		unique case (state_q)
			S_CPD: begin
				n_put  = !cp_txt_q;
				t_put  = cp_txt_q;
				n_byte = pb;
			end
			S_NW: begin
				if (!first_q && pb != PTR_MARK) begin
					n_put  = 1'b1;
					n_byte = (pb == 8'd0) ? 8'd0 : DOT_CHAR;
				end
			end
			S_BRA:   n_put = ncnt_q != '0;
			S_BRE: begin
				n_put  = 1'b1;
				n_byte = (pb == 8'd0) ? 8'd0 : DOT_CHAR;
			end
			S_TEND:  t_term = 1'b1;
			default: n_put = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ret_q    <= S_IDLE;
			cret_q   <= S_IDLE;
			gmode_q  <= G_RR;
			pcnt_q   <= '0;
			pa_q     <= '0;
			pos_q    <= '0;
			wp_q     <= '0;
			nstart_q <= '0;
			rec_q    <= '0;
			total_q  <= '0;
			rdlen_q  <= '0;
			hi_q     <= '0;
			cp_n_q   <= '0;
			sh_q     <= '0;
			f_q      <= '0;
			used_q   <= '0;
			first_q  <= 1'b0;
			cp_txt_q <= 1'b0;
			rd_txt_q <= 1'b0;
			rd_ok_q  <= 1'b0;
			ncnt_q   <= '0;
			nhw_q    <= '0;
			tcnt_q   <= '0;
			thw_q    <= '0;
			addr_q   <= '0;
			port_q   <= '0;
			terr_q   <= 1'b0;
			status_q <= ST_OK;
			res_q    <= '0;
			nwe_q    <= 1'b0;
			twe_q    <= 1'b0;
			nwa_q    <= '0;
			nwd_q    <= '0;
			twa_q    <= '0;
			twd_q    <= '0;
			nra_q    <= '0;
			tra_q    <= '0;
		end else begin
			nwe_q <= 1'b0;
			twe_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cq_vld) begin
						unique case (cq_head.kind)
							CMD_BYTE: begin
								if (pwe) begin
									pcnt_q <= pcnt_q + 1'b1;
								end
							end
							CMD_LAST: begin
								if (pwe) begin
									pcnt_q <= pcnt_q + 1'b1;
								end
								state_q <= S_START;
							end
							CMD_RD_NAME: begin
								nra_q    <= nidx[NAW-1:0];
								rd_ok_q  <= nidx < NXW'(nhw_q);
								rd_txt_q <= 1'b0;
								state_q  <= S_RD1;
							end
							CMD_RD_TEXT: begin
								tra_q    <= tidx[TAW-1:0];
								rd_ok_q  <= tidx < TXW'(thw_q);
								rd_txt_q <= 1'b1;
								state_q  <= S_RD1;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_RD1: state_q <= S_RD2;
				S_RD2: begin
					res_q      <= '0;
					res_q.kind <= rd_txt_q ? RK_TEXT : RK_NAME;
					res_q.data <= !rd_ok_q ? 8'd0 : (rd_txt_q ? trd_s1 : nrd_s1);
					state_q    <= S_OUT;
				end
				S_START: begin
					ncnt_q   <= '0;
					nhw_q    <= '0;
					tcnt_q   <= '0;
					thw_q    <= '0;
					addr_q   <= '0;
					port_q   <= '0;
					terr_q   <= 1'b0;
					status_q <= ST_OK;
					total_q  <= '0;
					if (pcnt_q < PCW'(HDR_LEN)) begin
						status_q <= ST_SHORT;
						state_q  <= S_FIN;
					end else begin
						pos_q   <= POS_W'(2);
						pa_q    <= POS_W'(2);
						ret_q   <= S_HDR;
						state_q <= S_WAIT;
					end
				end
				S_WAIT: state_q <= ret_q;
				S_HDR: begin
					// header bytes 2..11: flags, question count, three record counts
					pos_q   <= pos_q + 1'b1;
					pa_q    <= pos_q + 1'b1;
					ret_q   <= S_HDR;
					state_q <= S_WAIT;
					unique case (pos_q[3:0])
						4'd2: begin
							if (!pb[7]) begin
								status_q <= ST_NOT_RESP;
								state_q  <= S_FIN;
							end
						end
						4'd4, 4'd5: begin
							if (pb != 8'd0) begin
								status_q <= ST_HAS_Q;
								state_q  <= S_FIN;
							end
						end
						4'd6, 4'd8, 4'd10: hi_q <= pb;
						4'd7, 4'd9: total_q <= hsum;
						4'd11: begin
							total_q <= hsum;
							rec_q   <= '0;
							pos_q   <= POS_W'(HDR_LEN);
							if (hsum == 16'd0) begin
								status_q <= ST_NO_REC;
								state_q  <= S_FIN;
							end else begin
								state_q <= S_REC;
							end
						end
						default: hi_q <= hi_q;
					endcase
				end
				S_REC: begin
					if (rec_q < total_q && pos_q < rxl) begin
						pa_q    <= pos_q;
						ret_q   <= S_SKIP;
						state_q <= S_WAIT;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_SKIP: begin
					if (pb == PTR_MARK) begin
						pos_q   <= pos_q + POS_W'(2);
						state_q <= S_RRH;
					end else if (pb == 8'd0) begin
						pos_q   <= pos_q + 1'b1;
						state_q <= S_RRH;
					end else begin
						pos_q   <= pos_q + POS_W'(pb) + 1'b1;
						pa_q    <= pos_q + POS_W'(pb) + 1'b1;
						ret_q   <= S_SKIP;
						state_q <= S_WAIT;
					end
				end
				S_RRH: begin
					if (pos_q >= rxl) begin
						status_q <= ST_OVERRUN;
						state_q  <= S_FIN;
					end else begin
						gmode_q <= G_RR;
						f_q     <= '0;
						state_q <= S_GF;
					end
				end
				S_GF: begin
					pa_q    <= pos_q + POS_W'(goff);
					ret_q   <= S_GD;
					state_q <= S_WAIT;
				end
				S_GD: begin
					sh_q    <= {sh_q[23:0], pb};
					f_q     <= f_q + 1'b1;
					state_q <= glast ? S_GEND : S_GF;
				end
				S_GEND: begin
					state_q <= S_NEXT;
					f_q     <= '0;
					unique case (gmode_q)
						G_RR: begin
							rdlen_q <= sh_q[15:0];
							if (sh_q[31:16] == TYPE_PTR) begin
								ncnt_q   <= '0;
								first_q  <= 1'b1;
								wp_q     <= pos_q + POS_W'(10);
								nstart_q <= pos_q + POS_W'(10);
								pa_q     <= pos_q + POS_W'(10);
								ret_q    <= S_NW;
								state_q  <= S_WAIT;
							end else if (sh_q[31:16] == TYPE_SRV) begin
								gmode_q <= G_SRV;
								state_q <= S_GF;
							end else if (sh_q[31:16] == TYPE_A) begin
								gmode_q <= G_A;
								state_q <= S_GF;
							end else if (sh_q[31:16] == TYPE_TXT) begin
								tcnt_q  <= '0;
								used_q  <= '0;
								wp_q    <= pos_q + POS_W'(10);
								state_q <= S_TX;
							end
						end
						G_A:     addr_q <= sh_q;
						G_SRV:   port_q <= sh_q[15:0];
						default: addr_q <= addr_q;
					endcase
				end
				S_NEXT: begin
					pos_q   <= pos_q + POS_W'(10) + POS_W'(rdlen_q);
					rec_q   <= rec_q + 1'b1;
					state_q <= S_REC;
				end
				S_NW: begin
					if (pb == PTR_MARK) begin
						pa_q    <= wp_q + 1'b1;
						ret_q   <= S_BRA;
						state_q <= S_WAIT;
					end else if (pb == 8'd0) begin
						state_q <= S_NEXT;
					end else begin
						first_q  <= 1'b0;
						wp_q     <= wp_q + 1'b1;
						cp_n_q   <= pb;
						cp_txt_q <= 1'b0;
						cret_q   <= S_NWF;
						state_q  <= S_CP;
					end
				end
				S_NWF: begin
					pa_q    <= wp_q;
					ret_q   <= S_NW;
					state_q <= S_WAIT;
				end
				S_BRA: begin
					wp_q    <= POS_W'(pb);
					state_q <= S_BRF;
				end
				S_BRF: begin
					// only references to earlier bytes are followed; a full store ends loops
					if (wp_q != '0 && wp_q < nstart_q && ncnt_q < NCW'(NAME_BYTES)) begin
						pa_q    <= wp_q;
						ret_q   <= S_BRC;
						state_q <= S_WAIT;
					end else begin
						state_q <= S_NEXT;
					end
				end
				S_BRC: begin
					if (pb == 8'd0) begin
						state_q <= S_NEXT;
					end else begin
						wp_q     <= wp_q + 1'b1;
						cp_n_q   <= pb;
						cp_txt_q <= 1'b0;
						cret_q   <= S_BRL;
						state_q  <= S_CP;
					end
				end
				S_BRL: begin
					pa_q    <= wp_q;
					ret_q   <= S_BRE;
					state_q <= S_WAIT;
				end
				S_BRE: begin
					if (pb == 8'd0) begin
						state_q <= S_NEXT;
					end else if (pb == PTR_MARK) begin
						pa_q    <= wp_q + 1'b1;
						ret_q   <= S_BRA2;
						state_q <= S_WAIT;
					end else begin
						state_q <= S_BRF;
					end
				end
				S_BRA2: begin
					wp_q    <= POS_W'(pb);
					state_q <= S_BRF;
				end
				S_CP: begin
					if (cp_n_q == 8'd0) begin
						state_q <= cret_q;
					end else begin
						pa_q    <= wp_q;
						ret_q   <= S_CPD;
						state_q <= S_WAIT;
					end
				end
				S_CPD: begin
					wp_q    <= wp_q + 1'b1;
					cp_n_q  <= cp_n_q - 1'b1;
					state_q <= S_CP;
				end
				S_TX: begin
					if (wp_q < rxl && used_q < {1'b0, rdlen_q}) begin
						pa_q    <= wp_q;
						ret_q   <= S_TXL;
						state_q <= S_WAIT;
					end else begin
						state_q <= S_TEND;
					end
				end
				S_TXL: begin
					used_q <= used_q + 1'b1;
					wp_q   <= wp_q + 1'b1;
					if (pb == 8'd0) begin
						state_q <= S_TEND;
					end else if ({8'd0, pb} >= rdlen_q) begin
						// oversized string ends the record, no terminator
						terr_q  <= 1'b1;
						state_q <= S_NEXT;
					end else begin
						used_q   <= used_q + 17'(pb) + 1'b1;
						cp_n_q   <= pb;
						cp_txt_q <= 1'b1;
						cret_q   <= S_TX;
						state_q  <= S_CP;
					end
				end
				S_TEND: state_q <= S_NEXT;
				S_FIN: begin
					res_q.kind   <= RK_SUMMARY;
					res_q.status <= status_q;
					res_q.addr   <= addr_q;
					res_q.port   <= port_q;
					res_q.nlen   <= 9'(ncnt_q);
					res_q.tlen   <= 10'(tcnt_q);
					res_q.terr   <= terr_q;
					res_q.data   <= 8'd0;
					pcnt_q       <= '0;
					state_q      <= S_OUT;
				end
				S_OUT: begin
					if (res_rdy) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			// store writes; the high marks bound what a read may return
			if (n_put && ncnt_q < NCW'(NAME_BYTES)) begin
				nwe_q  <= 1'b1;
				nwa_q  <= ncnt_q[NAW-1:0];
				nwd_q  <= n_byte;
				ncnt_q <= ncnt_q + 1'b1;
				if (ncnt_q >= nhw_q) begin
					nhw_q <= ncnt_q + 1'b1;
				end
			end
			if ((t_put || t_term) && tcnt_q < TCW'(TEXT_BYTES)) begin
				twe_q <= 1'b1;
				twa_q <= tcnt_q[TAW-1:0];
				twd_q <= t_term ? 8'd0 : pb;
				if (t_put) begin
					tcnt_q <= tcnt_q + 1'b1;
				end
				if (tcnt_q >= thw_q) begin
					thw_q <= tcnt_q + 1'b1;
				end
			end
		end
	end

	a_pcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pcnt_q <= PCW'(PACKET_BYTES))
		else $error("packet count above buffer size");

	a_name_mark: assert property (@(posedge clk) disable iff (!arst_n)
		nhw_q >= ncnt_q && nhw_q <= NCW'(NAME_BYTES))
		else $error("name fill mark behind name count");

	a_text_mark: assert property (@(posedge clk) disable iff (!arst_n)
		thw_q >= tcnt_q && thw_q <= TCW'(TEXT_BYTES))
		else $error("text fill mark behind text count");

endmodule

### rtl/mdns_response_record_parser.sv
`timescale 1ns / 1ps
// mDNS response record parser, top level: command queue, parse engine, result queue.
// Depends on mdns_rrp_pkg, mdns_rrp_front, mdns_rrp_engine.
// Packet bytes are taken one per cycle while the command queue is not full; a read result is
// registered in the engine and in the result queue before it reaches the output ports.
// Parsing reads packet bytes through the single packet-buffer read port; the summary
// follows the last byte once the record walk ends.
// Pushes during a parse fill the four-entry command queue, then full holds.
// Reset clears queues, counters and store fill marks; store contents are not cleared.
module mdns_response_record_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  operation,
	input  logic [7:0]  packet_byte,
	input  logic        last_byte,
	input  logic [8:0]  read_index,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  result_kind,
	output logic [2:0]  parse_status,
	output logic [31:0] ipv4_address,
	output logic [15:0] service_port,
	output logic [8:0]  name_length,
	output logic [9:0]  text_length,
	output logic        text_error,
	output logic [7:0]  data_byte
);
	import mdns_rrp_pkg::*;

	logic       cq_vld;
	logic       cq_pop;
	cmd_t       cq_head;
	logic       res_vld;
	logic       res_rdy;
	res_t       eng_res;
	res_t       oq_q [2];
	logic       owp_q, orp_q;
	logic [1:0] ocnt_q;
	logic       oenq, odeq;
	res_t       head;

	mdns_rrp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.operation   (operation),
		.packet_byte (packet_byte),
		.last_byte   (last_byte),
		.read_index  (read_index),
		.cq_vld      (cq_vld),
		.cq_head     (cq_head),
		.cq_pop      (cq_pop)
	);

	mdns_rrp_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.cq_vld  (cq_vld),
		.cq_head (cq_head),
		.cq_pop  (cq_pop),
		.res_vld (res_vld),
		.res     (eng_res),
		.res_rdy (res_rdy)
	);

	// two-entry result queue parts the engine from the consumer
	assign res_rdy = ocnt_q != 2'd2;
	assign oenq    = res_vld && res_rdy;
	assign empty   = ocnt_q == 2'd0;
	assign odeq    = pop && !empty;
	assign head    = oq_q[orp_q];

	assign result_kind  = head.kind;
	assign parse_status = head.status;
	assign ipv4_address = head.addr;
	assign service_port = head.port;
	assign name_length  = head.nlen;
	assign text_length  = head.tlen;
	assign text_error   = head.terr;
	assign data_byte    = head.data;

	always_ff @(posedge clk) begin
		if (oenq) begin
			oq_q[owp_q] <= eng_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owp_q  <= 1'b0;
			orp_q  <= 1'b0;
			ocnt_q <= 2'd0;
		end else begin
			if (oenq) begin
				owp_q <= ~owp_q;
			end
			if (odeq) begin
				orp_q <= ~orp_q;
			end
			if (oenq && !odeq) begin
				ocnt_q <= ocnt_q + 1'b1;
			end else if (!oenq && odeq) begin
				ocnt_q <= ocnt_q - 1'b1;
			end
		end
	end

endmodule
